/* rtl/gbc_pkg.sv */
// Shared types, tables and round functions of the GOST 128-bit block cipher core.
`timescale 1ns / 1ps
`default_nettype none
package gbc_pkg;

   typedef logic [127:0] blk_type;
   typedef blk_type [9:0] rkeys_type;
   typedef logic [7:0] sbox_type [256];
   typedef blk_type kconst_type [32];
   typedef logic [7:0] coef_type [16];

   localparam int KeyWords = 4;
   localparam int CsrIndexWidth = 8;

   // Register indexes of the configuration port
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_WORD0 = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_WORD1 = 8'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_WORD2 = 8'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_WORD3 = 8'd3;

   // Operation codes carried in tuser
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam sbox_type SBOX = '{
      8'd252, 8'd238, 8'd221, 8'd17, 8'd207, 8'd110, 8'd49, 8'd22, 8'd251, 8'd196, 8'd250,
      8'd218, 8'd35, 8'd197, 8'd4, 8'd77, 8'd233, 8'd119, 8'd240, 8'd219, 8'd147, 8'd46,
      8'd153, 8'd186, 8'd23, 8'd54, 8'd241, 8'd187, 8'd20, 8'd205, 8'd95, 8'd193, 8'd249,
      8'd24, 8'd101, 8'd90, 8'd226, 8'd92, 8'd239, 8'd33, 8'd129, 8'd28, 8'd60, 8'd66,
      8'd139, 8'd1, 8'd142, 8'd79, 8'd5, 8'd132, 8'd2, 8'd174, 8'd227, 8'd106, 8'd143,
      8'd160, 8'd6, 8'd11, 8'd237, 8'd152, 8'd127, 8'd212, 8'd211, 8'd31, 8'd235, 8'd52,
      8'd44, 8'd81, 8'd234, 8'd200, 8'd72, 8'd171, 8'd242, 8'd42, 8'd104, 8'd162, 8'd253,
      8'd58, 8'd206, 8'd204, 8'd181, 8'd112, 8'd14, 8'd86, 8'd8, 8'd12, 8'd118, 8'd18,
      8'd191, 8'd114, 8'd19, 8'd71, 8'd156, 8'd183, 8'd93, 8'd135, 8'd21, 8'd161, 8'd150,
      8'd41, 8'd16, 8'd123, 8'd154, 8'd199, 8'd243, 8'd145, 8'd120, 8'd111, 8'd157,
      8'd158, 8'd178, 8'd177, 8'd50, 8'd117, 8'd25, 8'd61, 8'd255, 8'd53, 8'd138, 8'd126,
      8'd109, 8'd84, 8'd198, 8'd128, 8'd195, 8'd189, 8'd13, 8'd87, 8'd223, 8'd245, 8'd36,
      8'd169, 8'd62, 8'd168, 8'd67, 8'd201, 8'd215, 8'd121, 8'd214, 8'd246, 8'd124,
      8'd34, 8'd185, 8'd3, 8'd224, 8'd15, 8'd236, 8'd222, 8'd122, 8'd148, 8'd176, 8'd188,
      8'd220, 8'd232, 8'd40, 8'd80, 8'd78, 8'd51, 8'd10, 8'd74, 8'd167, 8'd151, 8'd96,
      8'd115, 8'd30, 8'd0, 8'd98, 8'd68, 8'd26, 8'd184, 8'd56, 8'd130, 8'd100, 8'd159,
      8'd38, 8'd65, 8'd173, 8'd69, 8'd70, 8'd146, 8'd39, 8'd94, 8'd85, 8'd47, 8'd140,
      8'd163, 8'd165, 8'd125, 8'd105, 8'd213, 8'd149, 8'd59, 8'd7, 8'd88, 8'd179, 8'd64,
      8'd134, 8'd172, 8'd29, 8'd247, 8'd48, 8'd55, 8'd107, 8'd228, 8'd136, 8'd217, 8'd231,
      8'd137, 8'd225, 8'd27, 8'd131, 8'd73, 8'd76, 8'd63, 8'd248, 8'd254, 8'd141, 8'd83,
      8'd170, 8'd144, 8'd202, 8'd216, 8'd133, 8'd97, 8'd32, 8'd113, 8'd103, 8'd164, 8'd45,
      8'd43, 8'd9, 8'd91, 8'd203, 8'd155, 8'd37, 8'd208, 8'd190, 8'd229, 8'd108, 8'd82,
      8'd89, 8'd166, 8'd116, 8'd210, 8'd230, 8'd244, 8'd180, 8'd192, 8'd209, 8'd102,
      8'd175, 8'd194, 8'd57, 8'd75, 8'd99, 8'd182
   };

   localparam coef_type LCOEF = '{
      8'd1, 8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1,
      8'd251, 8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148
   };

   // Multiply in GF(2^8), polynomial x^8+x^7+x^6+x+1
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      logic [7:0] aa;
      r = 8'd0;
      aa = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r = r ^ aa;
         aa = aa[7] ? ((aa << 1) ^ 8'hC3) : (aa << 1);
      end
      return r;
   endfunction

   // One LFSR step of the linear layer: new top byte, the rest shifts down
   function automatic blk_type lstep_fwd(input blk_type x);
      logic [7:0] s;
      s = 8'd0;
      for (int k = 0; k < 16; k++) s = s ^ gf_mul(LCOEF[k], x[8*k +: 8]);
      return {s, x[127:8]};
   endfunction

   // Inverse LFSR step: new bottom byte, the rest shifts up
   function automatic blk_type lstep_inv(input blk_type x);
      logic [7:0] s;
      s = x[127:120];
      for (int k = 0; k < 15; k++) s = s ^ gf_mul(LCOEF[k+1], x[8*k +: 8]);
      return {x[119:0], s};
   endfunction

   // Half of the linear layer (eight steps)
   function automatic blk_type half_fwd(input blk_type x);
      blk_type t;
      t = x;
      for (int i = 0; i < 8; i++) t = lstep_fwd(t);
      return t;
   endfunction

   function automatic blk_type half_inv(input blk_type x);
      blk_type t;
      t = x;
      for (int i = 0; i < 8; i++) t = lstep_inv(t);
      return t;
   endfunction

   function automatic sbox_type gen_sinv();
      sbox_type t;
      for (int i = 0; i < 256; i++) t[SBOX[i]] = i[7:0];
      return t;
   endfunction

   localparam sbox_type SINV = gen_sinv();

   function automatic blk_type sub_fwd(input blk_type x);
      blk_type t;
      for (int k = 0; k < 16; k++) t[8*k +: 8] = SBOX[x[8*k +: 8]];
      return t;
   endfunction

   function automatic blk_type sub_inv(input blk_type x);
      blk_type t;
      for (int k = 0; k < 16; k++) t[8*k +: 8] = SINV[x[8*k +: 8]];
      return t;
   endfunction

   // Key schedule constants C_i = L(i), i = 1..32, built at elaboration
   function automatic kconst_type gen_key_const();
      kconst_type c;
      blk_type t;
      for (int i = 0; i < 32; i++) begin
         t = '0;
         t[7:0] = 8'(i + 1);
         for (int s = 0; s < 16; s++) t = lstep_fwd(t);
         c[i] = t;
      end
      return c;
   endfunction

   localparam kconst_type KEY_CONST = gen_key_const();

endpackage
`default_nettype wire

/* rtl/gbc_cell.sv */
// Half-round cell of the cipher chain: one register stage with bubble-collapsing handshake.
`timescale 1ns / 1ps
`default_nettype none
module gbc_cell #(
   parameter bit SECOND = 1'b0
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire logic            in_op,
   input  wire gbc_pkg::blk_type in_data,
   input  wire gbc_pkg::blk_type round_key,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output logic                 out_op,
   output gbc_pkg::blk_type     out_data
);
   import gbc_pkg::*;

   logic    valid_ff, valid_in;
   logic    op_ff;
   blk_type data_ff, data_in;

   // stage takes a new request when empty or when its content moves on
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // first half: key + S then half of L (enc) / half of L^-1 (dec)
   // second half: rest of L (enc) / rest of L^-1, S^-1, key (dec)
   always_comb begin
      if (!SECOND) begin
         if (in_op == OP_DECRYPT) data_in = half_inv(in_data);
         else                     data_in = half_fwd(sub_fwd(in_data ^ round_key));
      end else begin
         if (in_op == OP_DECRYPT) data_in = sub_inv(half_inv(in_data)) ^ round_key;
         else                     data_in = half_fwd(in_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         op_ff   <= in_op;
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_op    = op_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

/* rtl/gbc_key_sched.sv */
// Key registers and iterative round-key expansion (one Feistel round unit, reused for every round).
`timescale 1ns / 1ps
`default_nettype none
module gbc_key_sched (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [gbc_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [63:0]                          csr_data,
   output logic                                      keys_ready,
   output gbc_pkg::rkeys_type                        rkey_bus
);
   import gbc_pkg::*;

   typedef enum logic [2:0] {
      KS_LOAD  = 3'b001,
      KS_RUN   = 3'b010,
      KS_READY = 3'b100
   } ks_state_type;

   ks_state_type state_ff, state_in;
   logic [63:0]  key_ff [KeyWords];
   logic [5:0]   cnt_ff, cnt_in;
   blk_type      a_ff, a_in, b_ff, b_in, tmp_ff, tmp_in;
   rkeys_type    rk_ff, rk_in;
   blk_type      feistel;
   logic         write_hit;
   logic [3:0]   rk_idx;

   assign csr_ready = 1'b1;
   assign write_hit = csr_valid && (csr_index == CSR_KEY_WORD0 || csr_index == CSR_KEY_WORD1 ||
                                    csr_index == CSR_KEY_WORD2 || csr_index == CSR_KEY_WORD3);

   // key words
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KeyWords; i++) key_ff[i] <= 64'd0;
      end else if (write_hit) begin
         key_ff[csr_index[1:0]] <= csr_data;
      end
   end

   // Feistel round: phase 0 does S and half of L, phase 1 the other half
   assign feistel = half_fwd(tmp_ff) ^ b_ff;
   assign rk_idx  = {1'b0, cnt_ff[5:4], 1'b0} + 4'd2;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      tmp_in   = tmp_ff;
      rk_in    = rk_ff;
      case (state_ff)
         KS_LOAD: begin
            a_in     = {key_ff[3], key_ff[2]};
            b_in     = {key_ff[1], key_ff[0]};
            rk_in[0] = {key_ff[3], key_ff[2]};
            rk_in[1] = {key_ff[1], key_ff[0]};
            cnt_in   = 6'd0;
            state_in = KS_RUN;
         end
         KS_RUN: begin
            cnt_in = cnt_ff + 6'd1;
            if (!cnt_ff[0]) begin
               tmp_in = half_fwd(sub_fwd(a_ff ^ KEY_CONST[cnt_ff[5:1]]));
            end else begin
               a_in = feistel;
               b_in = a_ff;
               // every eighth round yields two round keys
               if (cnt_ff[3:1] == 3'd7) begin
                  for (int i = 2; i < 10; i++) begin
                     if (rk_idx == 4'(i))     rk_in[i] = feistel;
                     if (rk_idx + 4'd1 == 4'(i)) rk_in[i] = a_ff;
                  end
               end
               if (cnt_ff == 6'd63) state_in = KS_READY;
            end
         end
         KS_READY: state_in = KS_READY;
         default:  state_in = KS_LOAD;
      endcase
      if (write_hit) state_in = KS_LOAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KS_LOAD;
         cnt_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      tmp_ff <= tmp_in;
      rk_ff  <= rk_in;
   end

   assign keys_ready = (state_ff == KS_READY);
   assign rkey_bus   = rk_ff;

endmodule
`default_nettype wire

/* rtl/gost_128bit_block_cipher_core.sv */
// Top level: GOST 128-bit block cipher core, a chain of eighteen half-round cells.
// Usage:
//   csr_*  : write key words 0..3 (index 0..3, others ignored) while no request is in flight.
//   req_*  : one 128-bit block per request; tuser selects encrypt (0) or decrypt (1).
//   rsp_*  : one 128-bit result per request, in request order.
// After reset and after every key write the round keys are expanded in a shared
// Feistel unit: a load step, then 32 rounds of two phases each, during which
// req_tready stays low.
// Each request passes through the 18 cells and then the output register.
// Throughput: one block per cycle unless the receiver stalls; each half round is one cell.
// Every cell holds its request when the next one is full and stalled, and moves it
// otherwise, so a stalled receiver fills the chain (up to 19 blocks) before
// req_tready drops; bubbles close up while the receiver waits.
// Reset clears all valid flags and the key words to zero.
`timescale 1ns / 1ps
`default_nettype none
module gost_128bit_block_cipher_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [127:0]                      req_tdata,  // block_low, block_high
   input  wire logic                              req_tuser,  // op
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [127:0]                           rsp_tdata,  // result_low, result_high
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [gbc_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [63:0]                       csr_data
);
   import gbc_pkg::*;

   localparam int Cells = 18;

   rkeys_type rk;
   logic      keys_ready;
   logic      c_valid [Cells+1];
   logic      c_ready [Cells+1];
   logic      c_op    [Cells+1];
   blk_type   c_data  [Cells+1];
   logic      rsp_valid_ff;
   blk_type   rsp_data_ff;
   logic      out_take;

   gbc_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .keys_ready (keys_ready),
      .rkey_bus   (rk)
   );

   // input: decryption starts with the last round key
   assign c_valid[0] = req_tvalid && keys_ready;
   assign req_tready = c_ready[0] && keys_ready;
   assign c_op[0]    = req_tuser;
   assign c_data[0]  = (req_tuser == OP_DECRYPT) ? (req_tdata ^ rk[9]) : req_tdata;

   for (genvar j = 0; j < Cells; j++) begin : g_cell
      localparam int Rnd = j / 2;
      blk_type key;
      assign key = (c_op[j] == OP_DECRYPT) ? rk[8-Rnd] : rk[Rnd];
      gbc_cell #(.SECOND(j % 2 == 1)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[j]),
         .in_ready  (c_ready[j]),
         .in_op     (c_op[j]),
         .in_data   (c_data[j]),
         .round_key (key),
         .out_valid (c_valid[j+1]),
         .out_ready (c_ready[j+1]),
         .out_op    (c_op[j+1]),
         .out_data  (c_data[j+1])
      );
   end

   // output register: encryption ends with the last round key
   assign c_ready[Cells] = !rsp_valid_ff || rsp_tready;
   assign out_take       = c_ready[Cells] && c_valid[Cells];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (c_ready[Cells]) begin
         rsp_valid_ff <= c_valid[Cells];
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         rsp_data_ff <= (c_op[Cells] == OP_DECRYPT) ? c_data[Cells] : (c_data[Cells] ^ rk[9]);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

/* verif/gost_128bit_block_cipher_core_tb.sv */
// Self-checking testbench of the GOST 128-bit block cipher core: random and directed blocks.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: software cipher, current key and the queue of predicted cipher results
class cipher_scoreboard;
   logic [63:0]  key_words [4];
   logic [127:0] rkey_tab [10];
   logic [7:0]   inv_sbox [256];
   bit           keys_valid;
   logic [127:0] expected_q [$];
   int           mismatches;

   function new();
      for (int i = 0; i < 256; i++) inv_sbox[gbc_pkg::SBOX[i]] = i[7:0];
      for (int i = 0; i < 4; i++) key_words[i] = '0;
      keys_valid = 0;
      mismatches = 0;
   endfunction

   function logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 0;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= x;
         x = x[7] ? ((x << 1) ^ 8'hC3) : (x << 1);
      end
      return acc;
   endfunction

   // Linear layer: sixteen LFSR steps, new byte enters at the top
   function logic [127:0] mix_fwd(input logic [127:0] v);
      logic [7:0] fb;
      for (int r = 0; r < 16; r++) begin
         fb = 0;
         for (int k = 0; k < 16; k++) fb ^= gmul(gbc_pkg::LCOEF[k], v[8*k +: 8]);
         v = {fb, v[127:8]};
      end
      return v;
   endfunction

   function logic [127:0] mix_inv(input logic [127:0] v);
      logic [7:0] fb;
      for (int r = 0; r < 16; r++) begin
         fb = v[127:120];
         for (int k = 0; k < 15; k++) fb ^= gmul(gbc_pkg::LCOEF[k+1], v[8*k +: 8]);
         v = {v[119:0], fb};
      end
      return v;
   endfunction

   function logic [127:0] subst(input logic [127:0] v, input bit inverse);
      for (int k = 0; k < 16; k++)
         v[8*k +: 8] = inverse ? inv_sbox[v[8*k +: 8]] : gbc_pkg::SBOX[v[8*k +: 8]];
      return v;
   endfunction

   // Feistel key schedule, 32 rounds, a pair of round keys every eight
   function void expand_keys();
      logic [127:0] a, b, t, c;
      a = {key_words[3], key_words[2]};
      b = {key_words[1], key_words[0]};
      rkey_tab[0] = a;
      rkey_tab[1] = b;
      for (int i = 0; i < 32; i++) begin
         c = mix_fwd(128'(i + 1));
         t = mix_fwd(subst(a ^ c, 0)) ^ b;
         b = a;
         a = t;
         if (i % 8 == 7) begin
            rkey_tab[2*(i/8) + 2] = a;
            rkey_tab[2*(i/8) + 3] = b;
         end
      end
      keys_valid = 1;
   endfunction

   function void write_key(input logic [7:0] idx, input logic [63:0] value);
      if (idx < 4) begin
         key_words[idx[1:0]] = value;
         keys_valid = 0;
      end
   endfunction

   function void note_request(input logic op, input logic [127:0] blk);
      if (!keys_valid) expand_keys();
      if (op == gbc_pkg::OP_ENCRYPT) begin
         for (int r = 0; r < 9; r++) blk = mix_fwd(subst(blk ^ rkey_tab[r], 0));
         blk ^= rkey_tab[9];
      end else begin
         blk ^= rkey_tab[9];
         for (int r = 8; r >= 0; r--) blk = subst(mix_inv(blk), 1) ^ rkey_tab[r];
      end
      expected_q.push_back(blk);
   endfunction

   function void check_result(input logic [127:0] got);
      logic [127:0] want;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h", got);
         return;
      end
      want = expected_q.pop_front();
      if (got[63:0] !== want[63:0] || got[127:64] !== want[127:64]) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: low exp %h got %h, high exp %h got %h",
                     want[63:0], got[63:0], want[127:64], got[127:64]);
      end
   endfunction
endclass

module gost_128bit_block_cipher_core_tb;
   import gbc_pkg::*;

   localparam int CycleLimit = 1000000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // block_low, block_high
   logic         req_tuser;   // op
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // result_low, result_high
   logic         csr_valid;
   logic         csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [63:0]  csr_data;

   cipher_scoreboard sb = new();
   int cycle_count = 0;
   int hold_len = 0;

   gost_128bit_block_cipher_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: check at the edge, change ready at the falling edge
   initial begin : result_sink
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         @(negedge clock);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 400);
         end
         mode_left--;
         if (hold_len > 0) begin
            hold_len--;
            rsp_tready = 1'b0;
         end else begin
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = 1'($urandom_range(0, 1));
               2: rsp_tready = (cycle_count % 7) < 4;
               default: rsp_tready = $urandom_range(0, 9) != 0;
            endcase
         end
      end
   end

   task automatic push_block(input logic op, input logic [127:0] blk);
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = blk;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, blk);
      @(negedge clock);
   endtask

   task automatic idle_gap(input int n);
      req_tvalid = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx, input logic [63:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_key(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_drain();
      while (sb.expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic load_key(input logic [255:0] key);
      for (int i = 0; i < KeyWords; i++) write_csr(i[7:0], key[64*i +: 64]);
   endtask

   function automatic logic [127:0] rand_block();
      logic [127:0] v;
      case ($urandom_range(0, 7))
         0: v = '0;
         1: v = '1;
         2: begin
            v = '0;
            v[8*$urandom_range(0, 15) +: 8] = 8'($urandom);
         end
         3: v = 128'(1) << $urandom_range(0, 127);
         4: for (int k = 0; k < 16; k++) v[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default: v = {$urandom, $urandom, $urandom, $urandom};
      endcase
      return v;
   endfunction

   // Random blocks in bursts with random gaps
   task automatic random_items(input int n);
      int left;
      int burst;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         if (burst > left) burst = left;
         for (int i = 0; i < burst; i++) push_block(1'($urandom_range(0, 1)), rand_block());
         left -= burst;
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 10));
      end
      req_tvalid = 1'b0;
   endtask

   initial begin : stimulus
      logic [255:0] key;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_ENCRYPT;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: zero key straight from reset, field extremes, both operations
      push_block(OP_ENCRYPT, '0);
      push_block(OP_DECRYPT, '0);
      push_block(OP_ENCRYPT, '1);
      push_block(OP_DECRYPT, '1);
      push_block(OP_ENCRYPT, {64'hFFFF_FFFF_FFFF_FFFF, 64'h0});
      push_block(OP_DECRYPT, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF});
      push_block(OP_ENCRYPT, {32{4'hA}});
      push_block(OP_DECRYPT, {32{4'h5}});
      idle_gap(3);
      wait_drain();

      // Standard test key, then ignored writes to unused register indexes
      load_key(256'h8899aabbccddeeff0011223344556677_fedcba98765432100123456789abcdef);
      write_csr(8'd4, '1);
      write_csr(8'hFF, 64'h0123_4567_89AB_CDEF);
      push_block(OP_ENCRYPT, 128'h1122334455667700ffeeddccbbaa9988);
      push_block(OP_DECRYPT, 128'h7f679d90bebc24305a468d42b9d4edcd);
      push_block(OP_ENCRYPT, 128'h1);
      push_block(OP_DECRYPT, 128'h1 << 127);
      idle_gap(2);
      wait_drain();

      // All-ones key
      load_key('1);
      push_block(OP_ENCRYPT, '0);
      push_block(OP_DECRYPT, '1);
      push_block(OP_ENCRYPT, 128'h8000_0000_0000_0001_8000_0000_0000_0001);
      idle_gap(1);
      wait_drain();

      // Long receiver stall while the sender keeps offering: chain fills up
      hold_len = 300;
      for (int i = 0; i < 60; i++) push_block(1'($urandom_range(0, 1)), rand_block());
      req_tvalid = 1'b0;
      wait_drain();

      // Random phases, each under a new key; first all-zero, then all-ones, then random ones
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: key = '0;
            1: key = '1;
            default: key = {$urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom};
         endcase
         load_key(key);
         if (ph == 3) write_csr(8'($urandom_range(4, 255)), {$urandom, $urandom});
         random_items(265);
         wait_drain();
      end

      repeat (40) @(negedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
